[rtl/sigma_clip_pixel_stream_defines.svh]
// Assertion macros shared by the sigma clip pixel stream design.
`ifndef SIGMA_CLIP_PIXEL_STREAM_DEFINES_SVH
`define SIGMA_CLIP_PIXEL_STREAM_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define SCP_ASSERT_NOW(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define SCP_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/scp_pkg.sv]
// Shared constants, codes and controller/datapath interface types.
package scp_pkg;

    localparam int PIXEL_COUNT_BITS_DEF = 24;
    localparam int PIX_W = 16;
    localparam int K_W   = 16;
    localparam int SD_W  = 24;
    localparam int QUO_W = 2 * SD_W;

    localparam logic [K_W-1:0]          K_SIGMA_RESET = 16'd1280;
    localparam logic signed [PIX_W-1:0] PIX_MIN       = 16'sh8000;
    localparam logic signed [PIX_W-1:0] PIX_MAX       = 16'sh7FFF;

    localparam logic FUNC_STATS = 1'b0;
    localparam logic FUNC_CLIP  = 1'b1;

    typedef enum logic [1:0] {
        MUL_SEL_NQ = 2'd0,
        MUL_SEL_S2 = 2'd1,
        MUL_SEL_D  = 2'd2
    } mul_sel_t;

    typedef enum logic {
        DIV_SEL_VAR  = 1'b0,
        DIV_SEL_MEAN = 1'b1
    } div_sel_t;

    typedef struct packed {
        logic     acc;
        logic     mul_start;
        mul_sel_t mul_sel;
        logic     div_start;
        div_sel_t div_sel;
        logic     sqrt_start;
        logic     bound_calc;
        logic     finish;
    } scp_cmd_t;

    typedef struct packed {
        logic mul_done;
        logic div_done;
        logic sqrt_done;
    } scp_stat_t;

endpackage

[rtl/scp_ctrl.sv]
// Sequencer for the statistics calculation at the end of a statistics pass.
module scp_ctrl (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             in_accept,
    input  logic             in_func,
    input  logic             in_last,
    input  logic             out_free,
    input  scp_pkg::scp_stat_t stat,
    output scp_pkg::scp_cmd_t  cmd,
    output logic             idle
);

    typedef enum logic [9:0] {
        ST_IDLE     = 10'b0000000001,
        ST_START    = 10'b0000000010,
        ST_MUL_NQ   = 10'b0000000100,
        ST_MUL_S2   = 10'b0000001000,
        ST_MUL_D    = 10'b0000010000,
        ST_DIV_VAR  = 10'b0000100000,
        ST_SQRT     = 10'b0001000000,
        ST_DIV_MEAN = 10'b0010000000,
        ST_BOUND    = 10'b0100000000,
        ST_FINISH   = 10'b1000000000
    } ctrl_state_t;

    ctrl_state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next      = state_reg;
        cmd             = '0;
        cmd.mul_sel     = scp_pkg::MUL_SEL_NQ;
        cmd.div_sel     = scp_pkg::DIV_SEL_VAR;
        case (state_reg)
            ST_IDLE: begin
                cmd.acc = in_accept && (in_func == scp_pkg::FUNC_STATS);
                if (cmd.acc && in_last) begin
                    state_next = ST_START;
                end
            end
            ST_START: begin
                cmd.mul_start = 1'b1;
                cmd.mul_sel   = scp_pkg::MUL_SEL_NQ;
                state_next    = ST_MUL_NQ;
            end
            ST_MUL_NQ: begin
                if (stat.mul_done) begin
                    cmd.mul_start = 1'b1;
                    cmd.mul_sel   = scp_pkg::MUL_SEL_S2;
                    state_next    = ST_MUL_S2;
                end
            end
            ST_MUL_S2: begin
                if (stat.mul_done) begin
                    cmd.mul_start = 1'b1;
                    cmd.mul_sel   = scp_pkg::MUL_SEL_D;
                    state_next    = ST_MUL_D;
                end
            end
            ST_MUL_D: begin
                if (stat.mul_done) begin
                    cmd.div_start = 1'b1;
                    cmd.div_sel   = scp_pkg::DIV_SEL_VAR;
                    state_next    = ST_DIV_VAR;
                end
            end
            ST_DIV_VAR: begin
                if (stat.div_done) begin
                    cmd.sqrt_start = 1'b1;
                    state_next     = ST_SQRT;
                end
            end
            ST_SQRT: begin
                if (stat.sqrt_done) begin
                    cmd.div_start = 1'b1;
                    cmd.div_sel   = scp_pkg::DIV_SEL_MEAN;
                    state_next    = ST_DIV_MEAN;
                end
            end
            ST_DIV_MEAN: begin
                if (stat.div_done) begin
                    state_next = ST_BOUND;
                end
            end
            ST_BOUND: begin
                cmd.bound_calc = 1'b1;
                state_next     = ST_FINISH;
            end
            ST_FINISH: begin
                // hold until the result register can take the statistics item
                if (out_free) begin
                    cmd.finish = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign idle = (state_reg == ST_IDLE);

endmodule

[rtl/scp_datapath.sv]
// Accumulators, shift-add multiplier, restoring divider, square root, bounds and clipping.
module scp_datapath #(
    parameter int PIXEL_COUNT_BITS = scp_pkg::PIXEL_COUNT_BITS_DEF
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  scp_pkg::scp_cmd_t                  cmd,
    output scp_pkg::scp_stat_t                 stat,
    input  logic [scp_pkg::K_W-1:0]            k_sigma_q8,
    input  logic signed [scp_pkg::PIX_W-1:0]   in_pixel,
    output logic signed [scp_pkg::PIX_W-1:0]   clip_pixel,
    output logic signed [scp_pkg::PIX_W-1:0]   low_bound,
    output logic signed [scp_pkg::PIX_W-1:0]   high_bound,
    output logic [scp_pkg::SD_W-1:0]           mean_q8,
    output logic [scp_pkg::SD_W-1:0]           stddev_q8
);

    localparam int P    = PIXEL_COUNT_BITS;
    localparam int CW   = P + 1;
    localparam int SW   = P + 17;
    localparam int SQW  = P + 31;
    localparam int MA   = P + 16;
    localparam int MB   = P + 31;
    localparam int MP   = MA + MB;
    localparam int DV   = 2 * P + 2;
    localparam int DDW  = MP + 16;
    localparam int QW   = scp_pkg::QUO_W;
    localparam int SDW  = scp_pkg::SD_W;
    localparam int SRW  = SDW + 3;
    localparam int KW   = scp_pkg::K_W;
    localparam int SPW  = KW + SDW;
    localparam int XW   = SPW + 2;
    localparam int QBW  = XW - 16;
    localparam int MCW  = $clog2(MA + 1);
    localparam int DCW  = $clog2(DDW + 1);
    localparam int SCW  = $clog2(SDW + 1);

    localparam logic signed [XW-1:0]  ROUND_ADD = XW'((1 << 16) - 1);
    localparam logic signed [QBW-1:0] QMIN      = QBW'(-32768);
    localparam logic signed [QBW-1:0] QMAX      = QBW'(32767);

    // accumulators
    logic [CW-1:0]         count_reg;
    logic signed [SW-1:0]  sum_reg;
    logic [SQW-1:0]        sumsq_reg;
    logic signed [31:0]    pix_sq;
    logic [SW-1:0]         sum_abs;
    logic [MA-1:0]         mag;

    assign pix_sq  = in_pixel * in_pixel;
    assign sum_abs = sum_reg[SW-1] ? SW'(-sum_reg) : SW'(sum_reg);
    assign mag     = sum_abs[MA-1:0];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
            sum_reg   <= '0;
            sumsq_reg <= '0;
        end else if (cmd.finish) begin
            count_reg <= '0;
            sum_reg   <= '0;
            sumsq_reg <= '0;
        end else if (cmd.acc && !count_reg[CW-1]) begin
            count_reg <= count_reg + CW'(1);
            sum_reg   <= sum_reg + {{(SW-16){in_pixel[15]}}, in_pixel};
            sumsq_reg <= sumsq_reg + {{(SQW-31){1'b0}}, pix_sq[30:0]};
        end
    end

    // shift-add multiplier, one multiplier bit per cycle
    logic [MA-1:0]     mul_a_reg;
    logic [MP-1:0]     mul_b_reg;
    logic [MP-1:0]     prod_reg;
    logic [MP-1:0]     prod_step;
    logic [MCW-1:0]    mul_cnt_reg;
    logic              mul_busy_reg;
    logic              mul_done_reg;
    scp_pkg::mul_sel_t mul_sel_reg;
    logic              mul_last;
    logic [MP-1:0]     nq_reg;
    logic [MP-1:0]     s2_reg;
    logic [DV-1:0]     d_reg;

    assign prod_step = prod_reg + (mul_a_reg[0] ? mul_b_reg : '0);
    assign mul_last  = mul_busy_reg && (mul_cnt_reg == MCW'(1));

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mul_busy_reg <= 1'b0;
            mul_done_reg <= 1'b0;
            mul_cnt_reg  <= '0;
        end else begin
            mul_done_reg <= mul_last;
            if (cmd.mul_start) begin
                mul_busy_reg <= 1'b1;
                mul_cnt_reg  <= MCW'(MA);
            end else if (mul_busy_reg) begin
                mul_cnt_reg <= mul_cnt_reg - MCW'(1);
                if (mul_last) begin
                    mul_busy_reg <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.mul_start) begin
            mul_sel_reg <= cmd.mul_sel;
            prod_reg    <= '0;
            case (cmd.mul_sel)
                scp_pkg::MUL_SEL_NQ: begin
                    mul_a_reg <= {{(MA-CW){1'b0}}, count_reg};
                    mul_b_reg <= {{(MP-SQW){1'b0}}, sumsq_reg};
                end
                scp_pkg::MUL_SEL_S2: begin
                    mul_a_reg <= mag;
                    mul_b_reg <= {{(MP-MA){1'b0}}, mag};
                end
                scp_pkg::MUL_SEL_D: begin
                    mul_a_reg <= {{(MA-CW){1'b0}}, count_reg - CW'(1)};
                    mul_b_reg <= {{(MP-CW){1'b0}}, count_reg};
                end
                default: begin
                    mul_a_reg <= '0;
                    mul_b_reg <= '0;
                end
            endcase
        end else if (mul_busy_reg) begin
            prod_reg  <= prod_step;
            mul_a_reg <= mul_a_reg >> 1;
            mul_b_reg <= mul_b_reg << 1;
            if (mul_last) begin
                case (mul_sel_reg)
                    scp_pkg::MUL_SEL_NQ: nq_reg <= prod_step;
                    scp_pkg::MUL_SEL_S2: s2_reg <= prod_step;
                    scp_pkg::MUL_SEL_D:  d_reg  <= prod_step[DV-1:0];
                    default:             d_reg  <= d_reg;
                endcase
            end
        end
    end

    // restoring divider, one quotient bit per cycle
    logic [DDW-1:0] dvd_reg;
    logic [DV-1:0]  dvs_reg;
    logic [DV-1:0]  rem_reg;
    logic [QW-1:0]  quo_reg;
    logic [DCW-1:0] div_cnt_reg;
    logic           div_busy_reg;
    logic           div_done_reg;
    logic           var_ok_reg;
    logic [DV:0]    rem_sh;
    logic           rem_ge;
    logic [DV:0]    rem_sub;
    logic           div_last;
    logic [MP-1:0]  num;

    assign num      = nq_reg - s2_reg;
    assign rem_sh   = {rem_reg, dvd_reg[DDW-1]};
    assign rem_ge   = rem_sh >= {1'b0, dvs_reg};
    assign rem_sub  = rem_sh - {1'b0, dvs_reg};
    assign div_last = div_busy_reg && (div_cnt_reg == DCW'(1));

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            div_busy_reg <= 1'b0;
            div_done_reg <= 1'b0;
            div_cnt_reg  <= '0;
        end else begin
            div_done_reg <= div_last;
            if (cmd.div_start) begin
                div_busy_reg <= 1'b1;
                div_cnt_reg  <= DCW'(DDW);
            end else if (div_busy_reg) begin
                div_cnt_reg <= div_cnt_reg - DCW'(1);
                if (div_last) begin
                    div_busy_reg <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.div_start) begin
            rem_reg <= '0;
            quo_reg <= '0;
            case (cmd.div_sel)
                scp_pkg::DIV_SEL_VAR: begin
                    dvd_reg    <= {num, 16'd0};
                    dvs_reg    <= d_reg;
                    var_ok_reg <= (count_reg > CW'(1)) && (nq_reg >= s2_reg);
                end
                scp_pkg::DIV_SEL_MEAN: begin
                    dvd_reg <= {{(DDW-MA-8){1'b0}}, mag, 8'd0};
                    dvs_reg <= {{(DV-CW){1'b0}}, count_reg};
                end
                default: begin
                    dvd_reg <= '0;
                    dvs_reg <= '0;
                end
            endcase
        end else if (div_busy_reg) begin
            dvd_reg <= dvd_reg << 1;
            rem_reg <= rem_ge ? rem_sub[DV-1:0] : rem_sh[DV-1:0];
            quo_reg <= {quo_reg[QW-2:0], rem_ge};
        end
    end

    // digit-by-digit square root, one result bit per cycle
    logic [QW-1:0]  rad_reg;
    logic [SRW-1:0] srem_reg;
    logic [SDW-1:0] root_reg;
    logic [SCW-1:0] sqrt_cnt_reg;
    logic           sqrt_busy_reg;
    logic           sqrt_done_reg;
    logic [SRW-1:0] srem_sh;
    logic [SRW-1:0] trial;
    logic           sq_ge;
    logic           sqrt_last;

    assign srem_sh   = {srem_reg[SRW-3:0], rad_reg[QW-1:QW-2]};
    assign trial     = {1'b0, root_reg, 2'b01};
    assign sq_ge     = srem_sh >= trial;
    assign sqrt_last = sqrt_busy_reg && (sqrt_cnt_reg == SCW'(1));

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sqrt_busy_reg <= 1'b0;
            sqrt_done_reg <= 1'b0;
            sqrt_cnt_reg  <= '0;
        end else begin
            sqrt_done_reg <= sqrt_last;
            if (cmd.sqrt_start) begin
                sqrt_busy_reg <= 1'b1;
                sqrt_cnt_reg  <= SCW'(SDW);
            end else if (sqrt_busy_reg) begin
                sqrt_cnt_reg <= sqrt_cnt_reg - SCW'(1);
                if (sqrt_last) begin
                    sqrt_busy_reg <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.sqrt_start) begin
            // fewer than two pixels or a negative numerator gives a deviation of zero
            rad_reg  <= var_ok_reg ? quo_reg : '0;
            srem_reg <= '0;
            root_reg <= '0;
        end else if (sqrt_busy_reg) begin
            rad_reg  <= rad_reg << 2;
            srem_reg <= sq_ge ? (srem_sh - trial) : srem_sh;
            root_reg <= {root_reg[SDW-2:0], sq_ge};
        end
    end

    assign stat.mul_done  = mul_done_reg;
    assign stat.div_done  = div_done_reg;
    assign stat.sqrt_done = sqrt_done_reg;

    // bounds
    logic signed [SDW:0]   mean_reg;
    logic [SPW-1:0]        spread_reg;
    logic signed [XW-1:0]  mean_x;
    logic signed [XW-1:0]  spread_x;

    always_ff @(posedge aclk) begin
        if (cmd.bound_calc) begin
            mean_reg   <= sum_reg[SW-1] ? -$signed(quo_reg[SDW:0]) : $signed(quo_reg[SDW:0]);
            spread_reg <= k_sigma_q8 * root_reg;
        end
    end

    assign mean_x   = {{(XW-SDW-9){mean_reg[SDW]}}, mean_reg, 8'd0};
    assign spread_x = {2'b00, spread_reg};

    function automatic logic signed [15:0] trunc_sat(input logic signed [XW-1:0] x);
        logic signed [XW-1:0]  t;
        logic signed [QBW-1:0] q;
        t = x[XW-1] ? (x + ROUND_ADD) : x;
        q = t[XW-1:16];
        if (q < QMIN) begin
            trunc_sat = scp_pkg::PIX_MIN;
        end else if (q > QMAX) begin
            trunc_sat = scp_pkg::PIX_MAX;
        end else begin
            trunc_sat = q[15:0];
        end
    endfunction

    assign low_bound  = trunc_sat(mean_x - spread_x);
    assign high_bound = trunc_sat(mean_x + spread_x);
    assign mean_q8    = mean_reg[SDW-1:0];
    assign stddev_q8  = root_reg;

    // latched clip window
    logic signed [15:0] clip_low_reg;
    logic signed [15:0] clip_high_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clip_low_reg  <= scp_pkg::PIX_MIN;
            clip_high_reg <= scp_pkg::PIX_MAX;
        end else if (cmd.finish) begin
            clip_low_reg  <= low_bound;
            clip_high_reg <= high_bound;
        end
    end

    always_comb begin
        if (in_pixel < clip_low_reg) begin
            clip_pixel = clip_low_reg;
        end else if (in_pixel > clip_high_reg) begin
            clip_pixel = clip_high_reg;
        end else begin
            clip_pixel = in_pixel;
        end
    end

endmodule

[rtl/sigma_clip_pixel_stream.sv]
// Top level of the two-pass sigma clipping pixel stream block.
//
// Statistics items (func 0) and clip items (func 1) are each taken at one item per
// cycle while the result register is free or being emptied; a statistics item that
// is not last gives no result, a clip item gives one clamped pixel in the next cycle.
// The last statistics item starts the end-of-pass calculation, during which no item
// is taken: three shift-add products (n*sumsq, sum^2, n*(n-1)), a restoring division
// for the variance, a square root and a restoring division for the mean, run in turn
// on the one-bit-per-cycle multiplier, divider and square-root units, then the bounds.
// The statistics item then waits for the result register. k_sigma_q8 is written
// through cfg_wen/cfg_wdata; the user must write it only while the block is idle,
// as the block itself does not enforce this. Clip items seen before any statistics
// pass are returned unchanged.
`include "sigma_clip_pixel_stream_defines.svh"

module sigma_clip_pixel_stream #(
    parameter int PIXEL_COUNT_BITS = scp_pkg::PIXEL_COUNT_BITS_DEF
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             cfg_wen,
    input  logic [scp_pkg::K_W-1:0]          cfg_wdata,
    input  logic                             s_valid,
    output logic                             s_ready,
    input  logic                             s_func,
    input  logic signed [scp_pkg::PIX_W-1:0] s_pixel,
    input  logic                             s_last,
    output logic                             m_valid,
    input  logic                             m_ready,
    output logic signed [scp_pkg::PIX_W-1:0] m_pixel_out,
    output logic                             m_stats_valid,
    output logic signed [scp_pkg::PIX_W-1:0] m_low_bound,
    output logic signed [scp_pkg::PIX_W-1:0] m_high_bound,
    output logic [scp_pkg::SD_W-1:0]         m_mean_q8,
    output logic [scp_pkg::SD_W-1:0]         m_stddev_q8
);

    scp_pkg::scp_cmd_t  cmd;
    scp_pkg::scp_stat_t stat;

    logic [scp_pkg::K_W-1:0]          k_reg;
    logic                             ctrl_idle;
    logic                             in_accept;
    logic                             out_free;
    logic                             clip_load;
    logic signed [scp_pkg::PIX_W-1:0] clip_pixel;
    logic signed [scp_pkg::PIX_W-1:0] low_bound;
    logic signed [scp_pkg::PIX_W-1:0] high_bound;
    logic [scp_pkg::SD_W-1:0]         mean_q8;
    logic [scp_pkg::SD_W-1:0]         stddev_q8;

    logic                             m_valid_reg;
    logic signed [scp_pkg::PIX_W-1:0] pixel_out_reg;
    logic                             stats_valid_reg;
    logic signed [scp_pkg::PIX_W-1:0] low_bound_reg;
    logic signed [scp_pkg::PIX_W-1:0] high_bound_reg;
    logic [scp_pkg::SD_W-1:0]         mean_q8_reg;
    logic [scp_pkg::SD_W-1:0]         stddev_q8_reg;

    // clip width register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            k_reg <= scp_pkg::K_SIGMA_RESET;
        end else if (cfg_wen) begin
            k_reg <= cfg_wdata;
        end
    end

    // take an item whenever the sequencer is idle and the result slot frees up
    assign out_free  = !m_valid_reg || m_ready;
    assign s_ready   = ctrl_idle && out_free;
    assign in_accept = s_valid && s_ready;
    assign clip_load = in_accept && (s_func == scp_pkg::FUNC_CLIP);

    scp_ctrl u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_accept (in_accept),
        .in_func   (s_func),
        .in_last   (s_last),
        .out_free  (out_free),
        .stat      (stat),
        .cmd       (cmd),
        .idle      (ctrl_idle)
    );

    scp_datapath #(
        .PIXEL_COUNT_BITS (PIXEL_COUNT_BITS)
    ) u_datapath (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cmd        (cmd),
        .stat       (stat),
        .k_sigma_q8 (k_reg),
        .in_pixel   (s_pixel),
        .clip_pixel (clip_pixel),
        .low_bound  (low_bound),
        .high_bound (high_bound),
        .mean_q8    (mean_q8),
        .stddev_q8  (stddev_q8)
    );

    // result register: hold until taken, load a clipped pixel or the statistics item
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (clip_load || cmd.finish) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (clip_load) begin
            pixel_out_reg   <= clip_pixel;
            stats_valid_reg <= 1'b0;
            low_bound_reg   <= '0;
            high_bound_reg  <= '0;
            mean_q8_reg     <= '0;
            stddev_q8_reg   <= '0;
        end else if (cmd.finish) begin
            pixel_out_reg   <= '0;
            stats_valid_reg <= 1'b1;
            low_bound_reg   <= low_bound;
            high_bound_reg  <= high_bound;
            mean_q8_reg     <= mean_q8;
            stddev_q8_reg   <= stddev_q8;
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_pixel_out   = pixel_out_reg;
    assign m_stats_valid = stats_valid_reg;
    assign m_low_bound   = low_bound_reg;
    assign m_high_bound  = high_bound_reg;
    assign m_mean_q8     = mean_q8_reg;
    assign m_stddev_q8   = stddev_q8_reg;

    // the clip window of a statistics item is never inverted
    `SCP_ASSERT_NOW(a_bounds_ordered, aclk, aresetn, m_valid && m_stats_valid, m_low_bound <= m_high_bound, "low bound above high bound")
    // closing a statistics pass makes the block busy in the next cycle
    `SCP_ASSERT_NEXT(a_busy_after_last, aclk, aresetn, s_valid && s_ready && (s_func == scp_pkg::FUNC_STATS) && s_last, !s_ready, "input taken during statistics calculation")
    // a clipped pixel item carries no statistics
    `SCP_ASSERT_NOW(a_clip_no_stats, aclk, aresetn, m_valid && !m_stats_valid, (m_mean_q8 == 0) && (m_stddev_q8 == 0) && (m_low_bound == 0), "statistics fields set on clip item")

endmodule
